FILE: rtl/srtts_pkg.sv
// shared constants, types and character helpers for the srt timestamp parser
package srtts_pkg;

  localparam int unsigned MAX_HOURS_DEF = 99999;

  localparam int unsigned CHAR_W  = 16;
  localparam int unsigned TOTAL_W = 39;
  localparam int unsigned MIN_W   = 7;
  localparam int unsigned FRAC_W  = 10;
  localparam int unsigned FDIG_W  = 2;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned PH_W    = 3;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_MALFORMED = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd3;

  // scanner phases
  localparam logic [PH_W-1:0] PH_LEAD    = 3'd0;
  localparam logic [PH_W-1:0] PH_HOURS   = 3'd1;
  localparam logic [PH_W-1:0] PH_MINUTES = 3'd2;
  localparam logic [PH_W-1:0] PH_SECONDS = 3'd3;
  localparam logic [PH_W-1:0] PH_FRAC    = 3'd4;
  localparam logic [PH_W-1:0] PH_IGNORE  = 3'd5;
  localparam logic [PH_W-1:0] PH_TRAIL   = 3'd6;

  // character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
  localparam logic [CHAR_W-1:0] CH_COLON = 16'h003A;
  localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;
  localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;

  localparam int unsigned MS_PER_HOUR = 3600000;
  localparam int unsigned MS_PER_MIN  = 60000;
  localparam int unsigned MS_PER_SEC  = 1000;
  localparam int unsigned FIELD_LIMIT = 60;
  localparam int unsigned FIELD_CAP   = 99;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [MIN_W-1:0]  minutes;
    logic [MIN_W-1:0]  seconds;
    logic [FRAC_W-1:0] frac;
    logic [FDIG_W-1:0] frac_digits;
  } snap_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    logic r;
    r = (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
        c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
        c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
        c == 16'h3000;
    return r;
  endfunction

endpackage

FILE: rtl/srt_timestamp_parser.sv
// srt timestamp parser top level: scanner plus result pipeline
//
// takes one utf-16 code unit per transaction and reports once per string
// on the unit marked is_last: status (ok, malformed, minutes or seconds out of range,
// hours overflow) and total_ms, the time in milliseconds, zero unless status is ok.
// surrounding whitespace is dropped, a ',' or '.' fraction gives up to three digits, and
// text after the fraction is ignored; an empty string is sent as one whitespace unit.
// throughput is one character per cycle while in_ready is high. out_valid rises once the
// last character has passed the snapshot, product and sum registers in turn. in_ready
// drops only when all three result stages hold a result and out_ready is low.
module srt_timestamp_parser #(
  parameter int unsigned MAX_HOURS = srtts_pkg::MAX_HOURS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [srtts_pkg::CHAR_W-1:0]  char_code,
  input  logic                          is_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srtts_pkg::ST_W-1:0]    status,
  output logic [srtts_pkg::TOTAL_W-1:0] total_ms
);
  import srtts_pkg::*;

  localparam int unsigned HOURS_W = $clog2(MAX_HOURS + 2);

  logic               take;
  logic               fin;
  snap_t              snap;
  logic [HOURS_W-1:0] hours;

  // an input transaction completes here
  assign take = in_valid && in_ready;

  // per-character state machine, emits a snapshot on the last character
  srtts_scan #(.MAX_HOURS(MAX_HOURS)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (char_code),
    .is_last   (is_last),
    .fin       (fin),
    .snap      (snap),
    .hours_out (hours)
  );

  // millisecond total, elastic so the scanner keeps running while a result waits
  srtts_total #(.MAX_HOURS(MAX_HOURS)) u_total (
    .clk       (clk),
    .rst       (rst),
    .fin       (fin),
    .snap      (snap),
    .hours_in  (hours),
    .take_ok   (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .total_ms  (total_ms)
  );

endmodule

FILE: rtl/srtts_scan.sv
// character scanner: per-character field state and the final status check
module srtts_scan #(
  parameter int unsigned MAX_HOURS = srtts_pkg::MAX_HOURS_DEF,
  localparam int unsigned HOURS_W = $clog2(MAX_HOURS + 2)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [srtts_pkg::CHAR_W-1:0] char_code,
  input  logic                         is_last,
  output logic                         fin,
  output srtts_pkg::snap_t             snap,
  output logic [HOURS_W-1:0]           hours_out
);
  import srtts_pkg::*;

  localparam int unsigned HX_W = HOURS_W + 4;
  localparam int unsigned MX_W = MIN_W + 3;

  logic [PH_W-1:0]    phase, phase_next, eff_phase;
  logic [HOURS_W-1:0] hours, hours_next;
  logic [MIN_W-1:0]   minutes, minutes_next;
  logic [MIN_W-1:0]   seconds, seconds_next;
  logic [FRAC_W-1:0]  frac, frac_next;
  logic [FDIG_W-1:0]  frac_digits, frac_digits_next;
  logic               has_digit, has_digit_next, eff_has;
  logic               err, err_next;

  logic               dig, space;
  logic [3:0]         d;
  logic [HX_W-1:0]    hv;
  logic [MX_W-1:0]    mv, sv;
  logic [FRAC_W-1:0]  fv;
  logic               bad, range_hit;

  assign dig   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign d     = dig ? char_code[3:0] : 4'd0;
  assign space = is_space(char_code);

  // decimal accumulate; hours, minutes and seconds saturate when stored
  assign hv = HX_W'(hours) * HX_W'(10) + HX_W'(d);
  assign mv = MX_W'(minutes) * MX_W'(10) + MX_W'(d);
  assign sv = MX_W'(seconds) * MX_W'(10) + MX_W'(d);
  assign fv = frac * FRAC_W'(10) + FRAC_W'(d);

  // leading whitespace is skipped; the first other character falls straight into the hours field
  assign eff_phase = (phase == PH_LEAD && !space) ? PH_HOURS : phase;
  assign eff_has   = (phase == PH_LEAD) ? 1'b0 : has_digit;

  always_comb begin
    phase_next       = phase;
    hours_next       = hours;
    minutes_next     = minutes;
    seconds_next     = seconds;
    frac_next        = frac;
    frac_digits_next = frac_digits;
    has_digit_next   = eff_has;
    err_next         = err;
    case (eff_phase)
      PH_LEAD: begin
      end
      PH_HOURS: begin
        phase_next = PH_HOURS;
        if (dig) begin
          hours_next = (hv > HX_W'(MAX_HOURS + 1)) ? HOURS_W'(MAX_HOURS + 1)
                                                   : hv[HOURS_W-1:0];
          has_digit_next = 1'b1;
        end else if (char_code == CH_COLON && eff_has) begin
          phase_next     = PH_MINUTES;
          has_digit_next = 1'b0;
        end else begin
          err_next   = 1'b1;
          phase_next = PH_IGNORE;
        end
      end
      PH_MINUTES: begin
        if (dig) begin
          minutes_next = (mv > MX_W'(FIELD_CAP)) ? MIN_W'(FIELD_CAP) : mv[MIN_W-1:0];
          has_digit_next = 1'b1;
        end else if (char_code == CH_COLON && eff_has) begin
          phase_next     = PH_SECONDS;
          has_digit_next = 1'b0;
        end else begin
          err_next   = 1'b1;
          phase_next = PH_IGNORE;
        end
      end
      PH_SECONDS: begin
        if (dig) begin
          seconds_next = (sv > MX_W'(FIELD_CAP)) ? MIN_W'(FIELD_CAP) : sv[MIN_W-1:0];
          has_digit_next = 1'b1;
        end else if ((char_code == CH_COMMA || char_code == CH_DOT) && eff_has) begin
          phase_next = PH_FRAC;
        end else if (space) begin
          phase_next = PH_TRAIL;
        end else begin
          err_next   = 1'b1;
          phase_next = PH_IGNORE;
        end
      end
      PH_FRAC: begin
        if (dig && frac_digits < FDIG_W'(3)) begin
          frac_next        = fv;
          frac_digits_next = frac_digits + FDIG_W'(1);
          if (frac_digits == FDIG_W'(2)) phase_next = PH_IGNORE;
        end else begin
          phase_next = PH_IGNORE;
        end
      end
      PH_TRAIL: begin
        if (!space) begin
          err_next   = 1'b1;
          phase_next = PH_IGNORE;
        end
      end
      default: begin
      end
    endcase
  end

  // end-of-string checks on the updated state
  always_comb begin
    bad = err_next || phase_next == PH_LEAD || phase_next == PH_HOURS ||
          phase_next == PH_MINUTES ||
          ((phase_next == PH_SECONDS || phase_next == PH_TRAIL) && !has_digit_next);
    range_hit = (minutes_next >= MIN_W'(FIELD_LIMIT)) ||
                (seconds_next >= MIN_W'(FIELD_LIMIT));
    snap      = '0;
    hours_out = '0;
    if (bad) begin
      snap.status = ST_MALFORMED;
    end else if (range_hit) begin
      snap.status = ST_RANGE;
    end else if (hours_next > HOURS_W'(MAX_HOURS)) begin
      snap.status = ST_OVERFLOW;
    end else begin
      snap.status      = ST_OK;
      snap.minutes     = minutes_next;
      snap.seconds     = seconds_next;
      snap.frac        = frac_next;
      snap.frac_digits = frac_digits_next;
      hours_out        = hours_next;
    end
  end

  assign fin = take && is_last;

  always_ff @(posedge clk) begin
    if (rst || fin) begin
      phase       <= PH_LEAD;
      hours       <= '0;
      minutes     <= '0;
      seconds     <= '0;
      frac        <= '0;
      frac_digits <= '0;
      has_digit   <= 1'b0;
      err         <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      hours       <= hours_next;
      minutes     <= minutes_next;
      seconds     <= seconds_next;
      frac        <= frac_next;
      frac_digits <= frac_digits_next;
      has_digit   <= has_digit_next;
      err         <= err_next;
    end
  end

endmodule

FILE: rtl/srtts_total.sv
// result pipeline: snapshot register, product register, summed output register
module srtts_total #(
  parameter int unsigned MAX_HOURS = srtts_pkg::MAX_HOURS_DEF,
  localparam int unsigned HOURS_W = $clog2(MAX_HOURS + 2)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fin,
  input  srtts_pkg::snap_t              snap,
  input  logic [HOURS_W-1:0]            hours_in,
  output logic                          take_ok,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srtts_pkg::ST_W-1:0]    status,
  output logic [srtts_pkg::TOTAL_W-1:0] total_ms
);
  import srtts_pkg::*;

  localparam int unsigned HP_W = HOURS_W + 22;
  localparam int unsigned MP_W = MIN_W + 16;
  localparam int unsigned SP_W = MIN_W + 10;

  logic               v1, v2;
  snap_t              s1;
  logic [HOURS_W-1:0] h1;
  logic [ST_W-1:0]    st2;
  logic [TOTAL_W-1:0] ph;
  logic [MP_W-1:0]    pm;
  logic [SP_W-1:0]    ps;
  logic [FRAC_W-1:0]  pf;
  logic [HP_W-1:0]    hprod;
  logic [FRAC_W-1:0]  ms_scaled;
  logic               o_free, s2_free, s1_free;

  assign o_free  = !out_valid || out_ready;
  assign s2_free = !v2 || o_free;
  assign s1_free = !v1 || s2_free;
  assign take_ok = s1_free;

  assign hprod = HP_W'(h1) * HP_W'(MS_PER_HOUR);

  // pad the fraction to milliseconds
  always_comb begin
    case (s1.frac_digits)
      2'd1:    ms_scaled = s1.frac * FRAC_W'(100);
      2'd2:    ms_scaled = s1.frac * FRAC_W'(10);
      2'd3:    ms_scaled = s1.frac;
      default: ms_scaled = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) v1 <= fin;
      if (s2_free) v2 <= v1;
      if (o_free)  out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && fin) begin
      s1 <= snap;
      h1 <= hours_in;
    end
    if (s2_free && v1) begin
      st2 <= s1.status;
      ph  <= TOTAL_W'(hprod);
      pm  <= MP_W'(s1.minutes) * MP_W'(MS_PER_MIN);
      ps  <= SP_W'(s1.seconds) * SP_W'(MS_PER_SEC);
      pf  <= ms_scaled;
    end
    if (o_free && v2) begin
      status   <= st2;
      total_ms <= ph + TOTAL_W'(pm) + TOTAL_W'(ps) + TOTAL_W'(pf);
    end
  end

endmodule

FILE: rtl/srtts_checker.sv
// port-level checks for the srt timestamp parser, bound to the top level
module srtts_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [srtts_pkg::CHAR_W-1:0]  char_code,
  input logic                          is_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [srtts_pkg::ST_W-1:0]    status,
  input logic [srtts_pkg::TOTAL_W-1:0] total_ms
);
  import srtts_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(total_ms))
    else $error("stalled result changed");

  // non-ok results carry no time
  a_zero_on_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> total_ms == '0)
    else $error("total_ms nonzero on error status");

  // input only backs up when the output is stalled
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // reset empties the result pipeline
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind srt_timestamp_parser srtts_checker u_srtts_checker (.*);
